FILE: hdl/uvs_pkg.sv
// Shared types, constants and helper functions of the UV sphere vertex generator.
// Used by every module in hdl; depends on nothing else.
package uvs_pkg;

    localparam int unsigned GRID_BITS_DEF = 8;
    localparam int unsigned DIV_STEPS     = 32;
    localparam int unsigned CORDIC_STEPS  = 24;
    localparam int unsigned MIN_COLUMNS   = 3;
    localparam int unsigned MIN_RINGS     = 2;
    localparam logic signed [31:0] CORDIC_GAIN = 32'sh26DD3B6A;

    // configuration register indexes
    localparam logic [1:0] REG_RADIUS  = 2'd0;
    localparam logic [1:0] REG_COLUMNS = 2'd1;
    localparam logic [1:0] REG_RINGS   = 2'd2;

    typedef struct packed {
        logic [15:0] upper;
        logic [15:0] lower;
        logic        vvalid;
        logic        qvalid;
    } t_side;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [1:0]         quad;
    } t_rot;

    typedef struct packed {
        logic signed [31:0] cs;
        logic signed [31:0] sn;
    } t_sc;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic               vertex_valid;
        logic [15:0]        upper_index;
        logic [15:0]        lower_index;
        logic               quad_valid;
    } t_result;

    // atan(2^-i) in 2^-32 turns
    function automatic logic signed [31:0] f_arc(input int unsigned i);
        logic signed [31:0] a;
        case (i)
            0:  a = 32'sh20000000;
            1:  a = 32'sh12E4051E;
            2:  a = 32'sh09FB385B;
            3:  a = 32'sh051111D4;
            4:  a = 32'sh028B0D43;
            5:  a = 32'sh0145D7E1;
            6:  a = 32'sh00A2F61E;
            7:  a = 32'sh00517C55;
            8:  a = 32'sh0028BE53;
            9:  a = 32'sh00145F2F;
            10: a = 32'sh000A2F98;
            11: a = 32'sh000517CC;
            12: a = 32'sh00028BE6;
            13: a = 32'sh000145F3;
            14: a = 32'sh0000A2FA;
            15: a = 32'sh0000517D;
            16: a = 32'sh000028BE;
            17: a = 32'sh0000145F;
            18: a = 32'sh00000A30;
            19: a = 32'sh00000518;
            20: a = 32'sh0000028C;
            21: a = 32'sh00000146;
            22: a = 32'sh000000A3;
            23: a = 32'sh00000051;
            default: a = 32'sh0;
        endcase
        return a;
    endfunction

    // fold a phase to within an eighth of a turn and seed the rotation
    function automatic t_rot f_fold(input logic [31:0] ph);
        t_rot        r;
        logic [31:0] s;
        logic [31:0] rest;
        s      = ph + 32'h2000_0000;
        r.quad = s[31:30];
        rest   = ph - {r.quad, 30'b0};
        r.x    = CORDIC_GAIN;
        r.y    = 32'sh0;
        r.z    = signed'(rest);
        return r;
    endfunction

    function automatic t_rot f_rot_step(input t_rot a, input int unsigned s);
        t_rot               b;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        dx = a.y >>> s;
        dy = a.x >>> s;
        b  = a;
        if (!a.z[31]) begin
            b.x = a.x - dx;
            b.y = a.y + dy;
            b.z = a.z - f_arc(s);
        end else begin
            b.x = a.x + dx;
            b.y = a.y - dy;
            b.z = a.z + f_arc(s);
        end
        return b;
    endfunction

    // undo the quarter-turn fold
    function automatic t_sc f_unfold(input t_rot a);
        t_sc r;
        case (a.quad)
            2'd0: begin
                r.cs = a.x;
                r.sn = a.y;
            end
            2'd1: begin
                r.cs = -a.y;
                r.sn = a.x;
            end
            2'd2: begin
                r.cs = -a.x;
                r.sn = -a.y;
            end
            default: begin
                r.cs = a.y;
                r.sn = -a.x;
            end
        endcase
        return r;
    endfunction

    // round half up by sh bits, then saturate
    function automatic logic signed [15:0] f_rnd_sat(input logic signed [63:0] v,
                                                     input int unsigned sh,
                                                     input logic signed [63:0] lo,
                                                     input logic signed [63:0] hi);
        logic signed [63:0] t;
        t = (v + (64'sd1 <<< (sh - 1))) >>> sh;
        if (t < lo) begin
            t = lo;
        end else if (t > hi) begin
            t = hi;
        end
        return t[15:0];
    endfunction

endpackage

FILE: hdl/uvs_div_cell.sv
// One restoring-division step for the two phase quotients (latitude and longitude).
// Depends on uvs_pkg.
module uvs_div_cell import uvs_pkg::*; #(
    parameter int unsigned GRID_BITS = GRID_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  t_side                  i_side,
    input  logic [GRID_BITS+1:0]   i_div_p,
    input  logic [GRID_BITS+1:0]   i_div_t,
    input  logic [GRID_BITS+1:0]   i_rem_p,
    input  logic [GRID_BITS+1:0]   i_rem_t,
    input  logic [DIV_STEPS-1:0]   i_quo_p,
    input  logic [DIV_STEPS-1:0]   i_quo_t,
    output logic                   o_valid,
    output t_side                  o_side,
    output logic [GRID_BITS+1:0]   o_rem_p,
    output logic [GRID_BITS+1:0]   o_rem_t,
    output logic [DIV_STEPS-1:0]   o_quo_p,
    output logic [DIV_STEPS-1:0]   o_quo_t
);
    localparam int unsigned RW = GRID_BITS + 2;

    logic          r_valid;
    t_side         r_side;
    logic [RW-1:0] r_rem_p, r_rem_t, n_rem_p, n_rem_t;
    logic [DIV_STEPS-1:0] r_quo_p, r_quo_t, n_quo_p, n_quo_t;
    logic [RW-1:0] w_sp, w_st;
    logic          w_gp, w_gt;

    always_comb begin
        w_sp    = {i_rem_p[RW-2:0], 1'b0};
        w_st    = {i_rem_t[RW-2:0], 1'b0};
        w_gp    = (w_sp >= i_div_p);
        w_gt    = (w_st >= i_div_t);
        n_rem_p = w_gp ? (w_sp - i_div_p) : w_sp;
        n_rem_t = w_gt ? (w_st - i_div_t) : w_st;
        n_quo_p = {i_quo_p[DIV_STEPS-2:0], w_gp};
        n_quo_t = {i_quo_t[DIV_STEPS-2:0], w_gt};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side  <= i_side;
            r_rem_p <= n_rem_p;
            r_rem_t <= n_rem_t;
            r_quo_p <= n_quo_p;
            r_quo_t <= n_quo_t;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_rem_p = r_rem_p;
    assign o_rem_t = r_rem_t;
    assign o_quo_p = r_quo_p;
    assign o_quo_t = r_quo_t;
endmodule

FILE: hdl/uvs_cordic_cell.sv
// One CORDIC rotation step for both angles of a grid point.
// Depends on uvs_pkg.
module uvs_cordic_cell import uvs_pkg::*; #(
    parameter int unsigned STEP = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_side i_side,
    input  t_rot  i_phi,
    input  t_rot  i_th,
    output logic  o_valid,
    output t_side o_side,
    output t_rot  o_phi,
    output t_rot  o_th
);
    logic  r_valid;
    t_side r_side;
    t_rot  r_phi, r_th;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_phi  <= f_rot_step(i_phi, STEP);
            r_th   <= f_rot_step(i_th, STEP);
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_phi   = r_phi;
    assign o_th    = r_th;
endmodule

FILE: hdl/uvs_post.sv
// Scaling stages: sine/cosine products, rounding, saturation and result masking.
// Depends on uvs_pkg.
module uvs_post import uvs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_side       i_side,
    input  t_rot        i_phi,
    input  t_rot        i_th,
    input  logic [15:0] i_radius,
    output logic        o_valid,
    output t_result     o_res
);
    logic [4:0] r_valid;
    t_side      r_side [4];

    // stage 0: unfold
    t_sc r0_phi, r0_th;
    // stage 1: first products
    logic signed [48:0] r1_ry, r1_rs;
    logic signed [63:0] r1_nx, r1_nz;
    logic signed [15:0] r1_ny;
    logic signed [31:0] r1_cth, r1_sth;
    // stage 2: ring radius and rounded terms
    logic signed [31:0] r2_q, r2_cth, r2_sth;
    logic signed [15:0] r2_py, r2_nx, r2_ny, r2_nz;
    // stage 3: ring products
    logic signed [63:0] r3_px, r3_pz;
    logic signed [15:0] r3_py, r3_nx, r3_ny, r3_nz;
    // stage 4: result
    t_result r4_res;

    logic signed [16:0] w_r;
    logic signed [48:0] w_q;
    logic               w_zero;
    t_side              w_s3;

    assign w_r = signed'({1'b0, i_radius});
    assign w_q = (r1_rs + 49'sd32768) >>> 16;
    assign w_s3 = r_side[3];
    assign w_zero = !w_s3.vvalid || (i_radius == 16'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_side[1] <= r_side[0];
            r_side[2] <= r_side[1];
            r_side[3] <= r_side[2];

            r0_phi <= f_unfold(i_phi);
            r0_th  <= f_unfold(i_th);

            r1_ry  <= w_r * r0_phi.cs;
            r1_rs  <= w_r * r0_phi.sn;
            r1_nx  <= r0_phi.sn * r0_th.cs;
            r1_nz  <= r0_phi.sn * r0_th.sn;
            r1_ny  <= f_rnd_sat(64'(r0_phi.cs), 16, -64'sd16384, 64'sd16384);
            r1_cth <= r0_th.cs;
            r1_sth <= r0_th.sn;

            r2_q   <= w_q[31:0];
            r2_py  <= f_rnd_sat(64'(r1_ry), 30, -64'sd32768, 64'sd32767);
            r2_nx  <= f_rnd_sat(r1_nx, 46, -64'sd16384, 64'sd16384);
            r2_nz  <= f_rnd_sat(r1_nz, 46, -64'sd16384, 64'sd16384);
            r2_ny  <= r1_ny;
            r2_cth <= r1_cth;
            r2_sth <= r1_sth;

            r3_px <= r2_q * r2_cth;
            r3_pz <= r2_q * r2_sth;
            r3_py <= r2_py;
            r3_nx <= r2_nx;
            r3_ny <= r2_ny;
            r3_nz <= r2_nz;

            // drop geometry for points off the grid or a zero radius
            r4_res.pos_x  <= w_zero ? 16'sd0
                                    : f_rnd_sat(r3_px, 44, -64'sd32768, 64'sd32767);
            r4_res.pos_z  <= w_zero ? 16'sd0
                                    : f_rnd_sat(r3_pz, 44, -64'sd32768, 64'sd32767);
            r4_res.pos_y  <= w_zero ? 16'sd0 : r3_py;
            r4_res.norm_x <= w_zero ? 16'sd0 : r3_nx;
            r4_res.norm_y <= w_zero ? 16'sd0 : r3_ny;
            r4_res.norm_z <= w_zero ? 16'sd0 : r3_nz;
            r4_res.vertex_valid <= w_s3.vvalid;
            r4_res.quad_valid   <= w_s3.qvalid;
            r4_res.upper_index  <= w_s3.vvalid ? w_s3.upper : 16'd0;
            r4_res.lower_index  <= w_s3.vvalid ? w_s3.lower : 16'd0;
        end
    end

    assign o_valid = r_valid[4];
    assign o_res   = r4_res;
endmodule

FILE: hdl/uv_sphere_vertex_generator_core.sv
// Top level of the UV sphere vertex generator: entry stage, division and CORDIC
// cell chains, scaling stages and output buffer. Depends on uvs_pkg and all cells.
//
// Use: a request carries a ring and a column number on i_ring_number and
// i_column_number, taken when i_valid and o_ready are both high. Each request
// gives exactly one result on the o_ fields, taken when o_valid and i_ready are
// both high. The user must write the registers (radius, column count, ring
// count) through i_cfg_we / i_cfg_idx / i_cfg_data only while no request is
// in flight; the block itself does not enforce this. Path from acceptance to
// o_valid: entry register, 32 division cells, 24 CORDIC cells, 5 scaling
// stages, output register. Throughput: one request per cycle while the skid
// register is empty; the chain of 32 one-bit division cells and 24 rotation
// cells is fully pipelined. Reset clears the valid bit of every stage and
// loads radius 1.0, 16 columns and 8 rings. When the receiver stalls, the
// output register holds and one more result lands in a skid register; only
// then does the whole chain hold and o_ready fall.
module uv_sphere_vertex_generator_core import uvs_pkg::*; #(
    parameter int unsigned GRID_BITS = GRID_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [GRID_BITS-1:0] i_ring_number,
    input  logic [GRID_BITS-1:0] i_column_number,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [15:0]   o_pos_x,
    output logic signed [15:0]   o_pos_y,
    output logic signed [15:0]   o_pos_z,
    output logic signed [15:0]   o_norm_x,
    output logic signed [15:0]   o_norm_y,
    output logic signed [15:0]   o_norm_z,
    output logic                 o_vertex_valid,
    output logic [15:0]          o_upper_index,
    output logic [15:0]          o_lower_index,
    output logic                 o_quad_valid
);
    localparam int unsigned G  = GRID_BITS;
    localparam int unsigned RW = GRID_BITS + 2;

    logic [15:0]  r_radius;
    logic [G-1:0] r_columns, r_rings;

    logic w_adv;

    // entry stage
    logic          r_e_valid;
    t_side         r_e_side, w_side;
    logic [RW-1:0] r_e_rem_p, r_e_rem_t, w_rem_t;
    logic [31:0]   w_prod;
    logic          w_legal;

    // division chain taps
    logic                 w_dv  [DIV_STEPS+1];
    t_side                w_ds  [DIV_STEPS+1];
    logic [RW-1:0]        w_rp  [DIV_STEPS+1];
    logic [RW-1:0]        w_rt  [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] w_qp  [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] w_qt  [DIV_STEPS+1];
    logic [RW-1:0]        w_div_p, w_div_t;

    // rotation chain taps
    logic  w_cv [CORDIC_STEPS+1];
    t_side w_cs [CORDIC_STEPS+1];
    t_rot  w_cp [CORDIC_STEPS+1];
    t_rot  w_ct [CORDIC_STEPS+1];

    logic    w_last_valid;
    t_result w_last;
    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius  <= 16'd256;
            r_columns <= G'(16);
            r_rings   <= G'(8);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RADIUS:  r_radius  <= i_cfg_data;
                REG_COLUMNS: r_columns <= i_cfg_data[G-1:0];
                REG_RINGS:   r_rings   <= i_cfg_data[G-1:0];
                default: ;
            endcase
        end
    end

    assign w_adv   = !r_skid_valid;
    assign o_ready = w_adv;

    always_comb begin
        w_legal = (r_columns >= G'(MIN_COLUMNS)) && (r_rings >= G'(MIN_RINGS));
        w_side.vvalid = w_legal && (i_ring_number <= r_rings)
                        && (i_column_number <= r_columns);
        w_side.qvalid = w_side.vvalid && (i_ring_number < r_rings)
                        && (i_column_number < r_columns);
        w_prod = 32'(i_ring_number) * (32'(r_columns) + 32'd1) + 32'(i_column_number);
        w_side.upper = w_prod[15:0];
        w_side.lower = w_prod[15:0] + 16'(r_columns) + 16'd1;
        // a full turn wraps to zero
        w_rem_t = (i_column_number >= r_columns) ? RW'(i_column_number - r_columns)
                                                 : RW'(i_column_number);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (w_adv) begin
            r_e_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_e_side  <= w_side;
            r_e_rem_p <= RW'(i_ring_number);
            r_e_rem_t <= w_rem_t;
        end
    end

    // ring*2^31/rings is taken as ring*2^32/(2*rings)
    assign w_div_p = {1'b0, r_rings, 1'b0};
    assign w_div_t = {2'b00, r_columns};

    assign w_dv[0] = r_e_valid;
    assign w_ds[0] = r_e_side;
    assign w_rp[0] = r_e_rem_p;
    assign w_rt[0] = r_e_rem_t;
    assign w_qp[0] = '0;
    assign w_qt[0] = '0;

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        uvs_div_cell #(.GRID_BITS(GRID_BITS)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_dv[k]),
            .i_side  (w_ds[k]),
            .i_div_p (w_div_p),
            .i_div_t (w_div_t),
            .i_rem_p (w_rp[k]),
            .i_rem_t (w_rt[k]),
            .i_quo_p (w_qp[k]),
            .i_quo_t (w_qt[k]),
            .o_valid (w_dv[k+1]),
            .o_side  (w_ds[k+1]),
            .o_rem_p (w_rp[k+1]),
            .o_rem_t (w_rt[k+1]),
            .o_quo_p (w_qp[k+1]),
            .o_quo_t (w_qt[k+1])
        );
    end

    assign w_cv[0] = w_dv[DIV_STEPS];
    assign w_cs[0] = w_ds[DIV_STEPS];
    assign w_cp[0] = f_fold(w_qp[DIV_STEPS]);
    assign w_ct[0] = f_fold(w_qt[DIV_STEPS]);

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
        uvs_cordic_cell #(.STEP(k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_cv[k]),
            .i_side  (w_cs[k]),
            .i_phi   (w_cp[k]),
            .i_th    (w_ct[k]),
            .o_valid (w_cv[k+1]),
            .o_side  (w_cs[k+1]),
            .o_phi   (w_cp[k+1]),
            .o_th    (w_ct[k+1])
        );
    end

    uvs_post u_post (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_valid  (w_cv[CORDIC_STEPS]),
        .i_side   (w_cs[CORDIC_STEPS]),
        .i_phi    (w_cp[CORDIC_STEPS]),
        .i_th     (w_ct[CORDIC_STEPS]),
        .i_radius (r_radius),
        .o_valid  (w_last_valid),
        .o_res    (w_last)
    );

    // output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_last_valid;
            end
        end else if (w_adv && w_last_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            r_out <= r_skid_valid ? r_skid : w_last;
        end else if (w_adv) begin
            r_skid <= w_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_pos_x        = r_out.pos_x;
    assign o_pos_y        = r_out.pos_y;
    assign o_pos_z        = r_out.pos_z;
    assign o_norm_x       = r_out.norm_x;
    assign o_norm_y       = r_out.norm_y;
    assign o_norm_z       = r_out.norm_z;
    assign o_vertex_valid = r_out.vertex_valid;
    assign o_upper_index  = r_out.upper_index;
    assign o_lower_index  = r_out.lower_index;
    assign o_quad_valid   = r_out.quad_valid;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without an output entry");

    a_quad_in_vertex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.quad_valid) |-> r_out.vertex_valid)
        else $error("cell flagged for a point off the grid");

    a_off_grid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.vertex_valid) |->
        (r_out.pos_x == 16'sd0 && r_out.norm_y == 16'sd0 && r_out.upper_index == 16'd0))
        else $error("off-grid result not cleared");

    a_lower_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.vertex_valid) |->
        (r_out.lower_index == 16'(r_out.upper_index + 16'(r_columns) + 16'd1)))
        else $error("lower index not one ring below");
endmodule
